### hdl/lsvg_pkg.sv
// ---------------------------------------------------------------------------
// lsvg_pkg
// shared types, constants and register codes of the sector velocity guard
// ---------------------------------------------------------------------------
package lsvg_pkg;

    // queue between the point/command classifier and the executor
    localparam int unsigned LSVG_QUEUE_DEPTH = 2;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned N_SECTORS  = 6;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GUARD_ENABLED = 3'd0,
        CFG_STOP_RADIUS   = 3'd1,
        CFG_SLOW_RADIUS   = 3'd2,
        CFG_SLOW_SPEED    = 3'd3,
        CFG_MOUNT_YAW     = 3'd4,
        CFG_MIN_RANGE     = 3'd5,
        CFG_MAX_RANGE     = 3'd6
    } t_cfg_idx;

    // register reset values
    localparam logic        RST_GUARD_ENABLED = 1'b1;
    localparam logic [15:0] RST_STOP_RADIUS   = 16'd1000;
    localparam logic [15:0] RST_SLOW_RADIUS   = 16'd1500;
    localparam logic [14:0] RST_SLOW_SPEED    = 15'd150;
    localparam logic [15:0] RST_MOUNT_YAW     = 16'd0;
    localparam logic [15:0] RST_MIN_RANGE     = 16'd0;
    localparam logic [15:0] RST_MAX_RANGE     = 16'hFFFF;

    // angle arithmetic in hundredths of a degree, wide enough for sum and wrap
    typedef logic signed [18:0] t_angle;

    localparam t_angle HALF_TURN   = 19'sd18000;
    localparam t_angle FULL_TURN   = 19'sd36000;
    localparam t_angle WRAP2_LIMIT = 19'sd54000;
    localparam t_angle HALF_SECTOR = 19'sd3000;
    localparam t_angle CTR_60      = 19'sd6000;
    localparam t_angle CTR_120     = 19'sd12000;

    // sector bits: fwd, fwd-left, fwd-right, back, back-left, back-right
    localparam int unsigned SEC_FWD     = 0;
    localparam int unsigned SEC_FWD_L   = 1;
    localparam int unsigned SEC_FWD_R   = 2;
    localparam int unsigned SEC_BACK    = 3;
    localparam int unsigned SEC_BACK_L  = 4;
    localparam int unsigned SEC_BACK_R  = 5;

    localparam logic [N_SECTORS-1:0] FWD_MASK   = 6'b000111;
    localparam logic [N_SECTORS-1:0] BWD_MASK   = 6'b111000;
    localparam logic [N_SECTORS-1:0] LEFT_MASK  = 6'b010010;
    localparam logic [N_SECTORS-1:0] RIGHT_MASK = 6'b100100;

    localparam logic signed [15:0] MOVE_THRESH = 16'sd10;

    // one classified word in the queue
    typedef struct packed {
        logic                    is_cmd;
        logic                    first;
        logic                    last;
        logic [N_SECTORS-1:0]    slow_hits;
        logic [N_SECTORS-1:0]    stop_hits;
        logic signed [15:0]      vx;
        logic signed [15:0]      vy;
        logic signed [15:0]      wz;
    } t_item;

    typedef struct packed {
        logic signed [15:0] mount_yaw;
        logic [15:0]        min_range;
        logic [15:0]        max_range;
        logic [15:0]        stop_radius;
        logic [15:0]        slow_radius;
    } t_front_cfg;

    typedef struct packed {
        logic        enabled;
        logic [14:0] slow_speed;
    } t_back_cfg;

    typedef struct packed {
        logic signed [15:0] value;
        logic               stopped;
        logic               limited;
    } t_axis_res;

endpackage

### hdl/lsvg_item_if.sv
// ---------------------------------------------------------------------------
// lsvg_item_if
// input channel: laser points and velocity commands
// ---------------------------------------------------------------------------
interface lsvg_item_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [15:0]        range_mm;
    logic               range_finite;
    logic signed [15:0] point_angle_cdeg;
    logic               scan_first;
    logic               scan_last;
    logic signed [15:0] cmd_linear_x;
    logic signed [15:0] cmd_linear_y;
    logic signed [15:0] cmd_angular_z;

    modport source (
        output valid, mode, range_mm, range_finite, point_angle_cdeg,
               scan_first, scan_last, cmd_linear_x, cmd_linear_y, cmd_angular_z,
        input  ready
    );

    modport sink (
        input  valid, mode, range_mm, range_finite, point_angle_cdeg,
               scan_first, scan_last, cmd_linear_x, cmd_linear_y, cmd_angular_z,
        output ready
    );
endinterface

### hdl/lsvg_result_if.sv
// ---------------------------------------------------------------------------
// lsvg_result_if
// output channel: guarded velocity commands
// ---------------------------------------------------------------------------
interface lsvg_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] safe_linear_x;
    logic signed [15:0] safe_linear_y;
    logic signed [15:0] safe_angular_z;
    logic               x_stopped;
    logic               y_stopped;
    logic               x_limited;
    logic               y_limited;

    modport source (
        output valid, safe_linear_x, safe_linear_y, safe_angular_z,
               x_stopped, y_stopped, x_limited, y_limited,
        input  ready
    );

    modport sink (
        input  valid, safe_linear_x, safe_linear_y, safe_angular_z,
               x_stopped, y_stopped, x_limited, y_limited,
        output ready
    );
endinterface

### hdl/lsvg_front.sv
// ---------------------------------------------------------------------------
// lsvg_front
// accepts input words, checks point validity and finds the hit sectors
// ---------------------------------------------------------------------------
module lsvg_front
    import lsvg_pkg::*;
(
    input  t_front_cfg  i_cfg,
    lsvg_item_if.sink   i_item,
    input  logic        i_queue_ready,
    output logic        o_push,
    output t_item       o_entry
);

    t_angle                 raw_angle;
    t_angle                 wrapped;
    logic [N_SECTORS-1:0]   hits;
    logic                   pt_valid;

    assign i_item.ready = i_queue_ready;
    assign o_push       = i_item.valid && i_queue_ready;

    // bearing plus mounting yaw, folded back into [-180, 180] degrees
    always_comb begin
        raw_angle = t_angle'(i_item.point_angle_cdeg) + t_angle'(i_cfg.mount_yaw);
        if (raw_angle > HALF_TURN) begin
            if (raw_angle > WRAP2_LIMIT) begin
                wrapped = raw_angle - FULL_TURN - FULL_TURN;
            end else begin
                wrapped = raw_angle - FULL_TURN;
            end
        end else if (raw_angle < -HALF_TURN) begin
            if (raw_angle < -WRAP2_LIMIT) begin
                wrapped = raw_angle + FULL_TURN + FULL_TURN;
            end else begin
                wrapped = raw_angle + FULL_TURN;
            end
        end else begin
            wrapped = raw_angle;
        end
    end

    // inclusive sector windows; edges hit both neighbours
    always_comb begin
        hits = '0;
        hits[SEC_FWD]    = (wrapped >= -HALF_SECTOR) && (wrapped <= HALF_SECTOR);
        hits[SEC_FWD_L]  = (wrapped >= CTR_60 - HALF_SECTOR)
                        && (wrapped <= CTR_60 + HALF_SECTOR);
        hits[SEC_FWD_R]  = (wrapped >= -CTR_60 - HALF_SECTOR)
                        && (wrapped <= -CTR_60 + HALF_SECTOR);
        hits[SEC_BACK]   = (wrapped >= HALF_TURN - HALF_SECTOR)
                        || (wrapped <= -HALF_TURN + HALF_SECTOR);
        hits[SEC_BACK_L] = (wrapped >= CTR_120 - HALF_SECTOR)
                        && (wrapped <= CTR_120 + HALF_SECTOR);
        hits[SEC_BACK_R] = (wrapped >= -CTR_120 - HALF_SECTOR)
                        && (wrapped <= -CTR_120 + HALF_SECTOR);
    end

    assign pt_valid = i_item.range_finite
                   && (i_item.range_mm >= i_cfg.min_range)
                   && (i_item.range_mm <= i_cfg.max_range);

    always_comb begin
        o_entry.is_cmd    = i_item.mode;
        o_entry.first     = i_item.scan_first;
        o_entry.last      = i_item.scan_last;
        o_entry.slow_hits = (pt_valid && (i_item.range_mm <= i_cfg.slow_radius))
                          ? hits : '0;
        o_entry.stop_hits = (pt_valid && (i_item.range_mm <= i_cfg.stop_radius))
                          ? hits : '0;
        o_entry.vx        = i_item.cmd_linear_x;
        o_entry.vy        = i_item.cmd_linear_y;
        o_entry.wz        = i_item.cmd_angular_z;
    end

endmodule

### hdl/lsvg_queue.sv
// ---------------------------------------------------------------------------
// lsvg_queue
// short in-order queue of classified words between front and back
// ---------------------------------------------------------------------------
module lsvg_queue
    import lsvg_pkg::*;
#(
    parameter int unsigned DEPTH = LSVG_QUEUE_DEPTH
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_entry,
    output logic    o_ready,
    input  logic    i_pop,
    output logic    o_head_valid,
    output t_item   o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_ready      = (r_count != CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### hdl/lsvg_back.sv
// ---------------------------------------------------------------------------
// lsvg_back
// folds points into the sector flags and guards commands against them
// ---------------------------------------------------------------------------
module lsvg_back
    import lsvg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_back_cfg       i_cfg,
    input  logic            i_head_valid,
    input  t_item           i_head,
    output logic            o_pop,
    lsvg_result_if.source   o_result
);

    logic [N_SECTORS-1:0]   r_work_stop, n_work_stop;
    logic [N_SECTORS-1:0]   r_work_slow, n_work_slow;
    logic [N_SECTORS-1:0]   r_held_stop, n_held_stop;
    logic [N_SECTORS-1:0]   r_held_slow, n_held_slow;

    logic                   r_out_valid, n_out_valid;
    logic signed [15:0]     r_out_vx, r_out_vy, r_out_wz;
    logic                   r_out_xs, r_out_ys, r_out_xl, r_out_yl;

    logic                   out_free;
    logic                   pop_cmd;
    logic                   pop_pt;
    t_axis_res              res_x;
    t_axis_res              res_y;

    function automatic t_axis_res guard_axis(
        input logic signed [15:0]   v,
        input logic [N_SECTORS-1:0] pos_mask,
        input logic [N_SECTORS-1:0] neg_mask,
        input logic [N_SECTORS-1:0] stop_f,
        input logic [N_SECTORS-1:0] slow_f,
        input logic [14:0]          cap
    );
        logic [N_SECTORS-1:0]   mask;
        logic [15:0]            mag;
        logic [15:0]            cap_w;
        t_axis_res              res;
        mask  = (v > MOVE_THRESH) ? pos_mask
              : (v < -MOVE_THRESH) ? neg_mask : '0;
        mag   = v[15] ? 16'(-v) : 16'(v);
        cap_w = {1'b0, cap};
        if (mag > cap_w) begin
            mag = cap_w;
        end
        res.stopped = |(stop_f & mask);
        res.limited = !res.stopped && |(slow_f & mask);
        if (res.stopped) begin
            res.value = '0;
        end else if (res.limited) begin
            res.value = v[15] ? signed'(16'(-mag)) : signed'(mag);
        end else begin
            res.value = v;
        end
        return res;
    endfunction

    // a point retires at once; a command waits for a free output register
    assign out_free = !r_out_valid || o_result.ready;
    assign pop_cmd  = i_head_valid && i_head.is_cmd && out_free;
    assign pop_pt   = i_head_valid && !i_head.is_cmd;
    assign o_pop    = pop_cmd || pop_pt;

    assign res_x = guard_axis(i_head.vx, FWD_MASK, BWD_MASK,
                              r_held_stop, r_held_slow, i_cfg.slow_speed);
    assign res_y = guard_axis(i_head.vy, LEFT_MASK, RIGHT_MASK,
                              r_held_stop, r_held_slow, i_cfg.slow_speed);

    always_comb begin
        n_work_stop = r_work_stop;
        n_work_slow = r_work_slow;
        n_held_stop = r_held_stop;
        n_held_slow = r_held_slow;
        if (pop_pt) begin
            n_work_stop = (i_head.first ? '0 : r_work_stop) | i_head.stop_hits;
            n_work_slow = (i_head.first ? '0 : r_work_slow) | i_head.slow_hits;
            if (i_head.last) begin
                n_held_stop = n_work_stop;
                n_held_slow = n_work_slow;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (pop_cmd) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_stop <= '0;
            r_work_slow <= '0;
            r_held_stop <= '0;
            r_held_slow <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_work_stop <= n_work_stop;
            r_work_slow <= n_work_slow;
            r_held_stop <= n_held_stop;
            r_held_slow <= n_held_slow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_cmd) begin
            r_out_wz <= i_head.wz;
            if (i_cfg.enabled) begin
                r_out_vx <= res_x.value;
                r_out_vy <= res_y.value;
                r_out_xs <= res_x.stopped;
                r_out_ys <= res_y.stopped;
                r_out_xl <= res_x.limited;
                r_out_yl <= res_y.limited;
            end else begin
                r_out_vx <= i_head.vx;
                r_out_vy <= i_head.vy;
                r_out_xs <= 1'b0;
                r_out_ys <= 1'b0;
                r_out_xl <= 1'b0;
                r_out_yl <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.safe_linear_x  = r_out_vx;
    assign o_result.safe_linear_y  = r_out_vy;
    assign o_result.safe_angular_z = r_out_wz;
    assign o_result.x_stopped      = r_out_xs;
    assign o_result.y_stopped      = r_out_ys;
    assign o_result.x_limited      = r_out_xl;
    assign o_result.y_limited      = r_out_yl;

endmodule

### hdl/lidar_sector_velocity_guard_core.sv
// ---------------------------------------------------------------------------
// lidar_sector_velocity_guard_core
// sector obstacle guard: laser points build stop/slow flags, commands obey them
// ---------------------------------------------------------------------------
//
//  channel    | dir | handshake    | word
//  -----------+-----+--------------+-----------------------------------------
//  i_item     | in  | valid/ready  | laser point or velocity command
//  o_result   | out | valid/ready  | guarded command, one per command word
//  i_cfg_*    | in  | write enable | register index and 16-bit data
//
//  one word per cycle sustained while o_result takes its words; a command
//  is written to the queue when accepted and passes from the queue head to
//  the output register once that register is free, where o_result presents it
//  points never produce a word, they only update the sector flags
//  while o_result stalls a command waits at the queue head and the words
//  behind it stay queued in order; i_item stalls once the queue is full
//  synchronous active-low reset clears flags, queue and config to defaults
//
module lidar_sector_velocity_guard_core
    import lsvg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = LSVG_QUEUE_DEPTH
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    lsvg_item_if.sink               i_item,
    lsvg_result_if.source           o_result,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic               r_guard_enabled;
    logic [15:0]        r_stop_radius;
    logic [15:0]        r_slow_radius;
    logic [14:0]        r_slow_speed;
    logic signed [15:0] r_mount_yaw;
    logic [15:0]        r_min_range;
    logic [15:0]        r_max_range;

    t_front_cfg         front_cfg;
    t_back_cfg          back_cfg;

    // front to queue, queue to back
    logic               push;
    logic               queue_ready;
    t_item              push_entry;
    logic               pop;
    logic               head_valid;
    t_item              head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_enabled <= RST_GUARD_ENABLED;
            r_stop_radius   <= RST_STOP_RADIUS;
            r_slow_radius   <= RST_SLOW_RADIUS;
            r_slow_speed    <= RST_SLOW_SPEED;
            r_mount_yaw     <= signed'(RST_MOUNT_YAW);
            r_min_range     <= RST_MIN_RANGE;
            r_max_range     <= RST_MAX_RANGE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GUARD_ENABLED: r_guard_enabled <= i_cfg_data[0];
                CFG_STOP_RADIUS:   r_stop_radius   <= i_cfg_data;
                CFG_SLOW_RADIUS:   r_slow_radius   <= i_cfg_data;
                CFG_SLOW_SPEED:    r_slow_speed    <= i_cfg_data[14:0];
                CFG_MOUNT_YAW:     r_mount_yaw     <= signed'(i_cfg_data);
                CFG_MIN_RANGE:     r_min_range     <= i_cfg_data;
                CFG_MAX_RANGE:     r_max_range     <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // the angle and range settings feed the classifier, enable and speed rule the back
    always_comb begin
        front_cfg.mount_yaw   = r_mount_yaw;
        front_cfg.min_range   = r_min_range;
        front_cfg.max_range   = r_max_range;
        front_cfg.stop_radius = r_stop_radius;
        front_cfg.slow_radius = r_slow_radius;
        back_cfg.enabled      = r_guard_enabled;
        back_cfg.slow_speed   = r_slow_speed;
    end

    // classify: validity window, yaw fold, six sector compares
    lsvg_front u_front (
        .i_cfg          (front_cfg),
        .i_item         (i_item),
        .i_queue_ready  (queue_ready),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    // in-order buffer so a stalled output does not stall the sensor side at once
    lsvg_queue #(
        .DEPTH          (QUEUE_DEPTH)
    ) u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_entry        (push_entry),
        .o_ready        (queue_ready),
        .i_pop          (pop),
        .o_head_valid   (head_valid),
        .o_head         (head)
    );

    // execute: flag update for points, stop/slow rule for commands
    lsvg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (back_cfg),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_result       (o_result)
    );

endmodule
